/* rtl/core/itds_pkg.sv */
// shared types, constants and the microcode table of the digit string converter
// no dependencies
package itds_pkg;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS = 8;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] DIGIT_LIMIT = 6'd10;

  localparam logic [7:0] CHAR_ZERO        = 8'h30;
  localparam logic [7:0] CHAR_LETTER_BASE = 8'h57;
  localparam logic [7:0] CHAR_MINUS       = 8'h2d;

  typedef struct packed {
    logic [31:0] value;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV,
    OP_PUSH,
    OP_SIGN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_DIV_MORE,
    CND_QUOT_NZ,
    CND_STACK_MORE
  } cond_e;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_IDLE = 3'd0;
  localparam pc_t PC_DIV  = 3'd1;
  localparam pc_t PC_PUSH = 3'd2;
  localparam pc_t PC_SIGN = 3'd3;
  localparam pc_t PC_EMIT = 3'd4;
  localparam pc_t PC_DONE = 3'd5;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic div_more;
    logic quot_nz;
    logic stack_more;
  } status_t;

  // jump to target when the condition holds, otherwise step to the next word
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE: w = '{op: OP_ACCEPT, cond: CND_NO_START,   target: PC_IDLE};
      PC_DIV:  w = '{op: OP_DIV,    cond: CND_DIV_MORE,   target: PC_DIV};
      PC_PUSH: w = '{op: OP_PUSH,   cond: CND_QUOT_NZ,    target: PC_DIV};
      PC_SIGN: w = '{op: OP_SIGN,   cond: CND_NEVER,      target: PC_IDLE};
      PC_EMIT: w = '{op: OP_EMIT,   cond: CND_STACK_MORE, target: PC_EMIT};
      PC_DONE: w = '{op: OP_NONE,   cond: CND_ALWAYS,     target: PC_IDLE};
      default: w = '{op: OP_NONE,   cond: CND_ALWAYS,     target: PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [5:0] clamp_radix(logic [5:0] r);
    logic [5:0] c;
    if (r < RADIX_MIN) begin
      c = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      c = RADIX_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_char(logic [5:0] d);
    logic [7:0] c;
    if (d < DIGIT_LIMIT) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_LETTER_BASE + {2'b00, d};
    end
    return c;
  endfunction

endpackage

/* rtl/core/itds_ram.sv */
// generic single write port ram with registered read
// no dependencies
module itds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* rtl/core/itds_seq.sv */
// microcode sequencer: step counter, control rom and jump conditions
// depends on itds_pkg
module itds_seq
  import itds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output uword_t  ctrl_o,
  output logic    busy
);

  pc_t    pc_q, pc_d;
  uword_t uword;
  logic   take;

  assign uword = ucode_rom(pc_q);

  always_comb begin
    case (uword.cond)
      CND_NEVER:      take = 1'b0;
      CND_ALWAYS:     take = 1'b1;
      CND_NO_START:   take = !start;
      CND_DIV_MORE:   take = status_i.div_more;
      CND_QUOT_NZ:    take = status_i.quot_nz;
      CND_STACK_MORE: take = status_i.stack_more;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = take ? uword.target : pc_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = uword;
  assign busy   = (pc_q != PC_IDLE);

endmodule

/* rtl/core/itds_dp.sv */
// datapath: radix register, shared divider, digit stack and character output
// depends on itds_pkg and itds_ram
module itds_dp
  import itds_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  in_i,
  input  uword_t    ctrl_i,
  output status_t   status_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output out_item_t out_o,
  output logic      out_strobe_o
);

  localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W     = DIV_STEPS * DIV_BITS;
  localparam int DCW       = $clog2(DIV_STEPS + 1);
  localparam int AW        = $clog2(VALUE_WIDTH);
  localparam int CW        = $clog2(VALUE_WIDTH + 1);

  logic [5:0]             radix_q;
  logic [PAD_W-1:0]       work_q, work_d;
  logic [5:0]             rem_q, rem_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          sp_q, sp_d;
  out_item_t              out_q, out_d;
  logic                   strobe_q, strobe_d;

  logic [VALUE_WIDTH+31:0] val_ext;
  logic [VALUE_WIDTH-1:0]  val_w;
  logic [VALUE_WIDTH-1:0]  mag;
  logic                    in_neg;

  logic [PAD_W-1:0] div_w;
  logic [6:0]       div_r;
  logic             div_bit;

  logic          ram_we;
  logic [AW-1:0] ram_rd_addr;
  logic [5:0]    ram_rd_data;

  // input value fitted to the working width, then sign stripped
  assign val_ext = {{VALUE_WIDTH{1'b0}}, in_i.value};
  assign val_w   = val_ext[VALUE_WIDTH-1:0];
  assign in_neg  = in_i.is_signed & val_w[VALUE_WIDTH-1];
  assign mag     = in_neg ? (~val_w + VALUE_WIDTH'(1)) : val_w;

  // DIV_BITS restoring steps on a remainder that stays below the radix
  always_comb begin
    div_w   = work_q;
    div_r   = {1'b0, rem_q};
    div_bit = 1'b0;
    for (int k = 0; k < DIV_BITS; k++) begin
      div_r   = {div_r[5:0], div_w[PAD_W-1]};
      div_bit = (div_r >= {1'b0, radix_q});
      if (div_bit) begin
        div_r = div_r - {1'b0, radix_q};
      end
      div_w = {div_w[PAD_W-2:0], div_bit};
    end
  end

  always_comb begin
    work_d   = work_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    neg_d    = neg_q;
    sp_d     = sp_q;
    out_d    = out_q;
    strobe_d = 1'b0;
    ram_we   = 1'b0;
    case (ctrl_i.op)
      OP_ACCEPT: begin
        if (start) begin
          work_d = PAD_W'(mag);
          rem_d  = '0;
          dcnt_d = DCW'(DIV_STEPS);
          neg_d  = in_neg;
          sp_d   = '0;
        end
      end
      OP_DIV: begin
        work_d = div_w;
        rem_d  = div_r[5:0];
        dcnt_d = dcnt_q - DCW'(1);
      end
      OP_PUSH: begin
        ram_we = 1'b1;
        sp_d   = sp_q + CW'(1);
        rem_d  = '0;
        dcnt_d = DCW'(DIV_STEPS);
      end
      OP_SIGN: begin
        if (neg_q) begin
          strobe_d        = 1'b1;
          out_d.character = CHAR_MINUS;
          out_d.last      = 1'b0;
        end
      end
      OP_EMIT: begin
        strobe_d        = 1'b1;
        out_d.character = digit_char(ram_rd_data);
        out_d.last      = (sp_q == CW'(1));
        sp_d            = sp_q - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // read the next top of stack so it is ready in the next cycle
  always_comb begin
    ram_rd_addr = AW'(sp_d - CW'(1));
  end

  assign status_o.div_more   = (dcnt_q > DCW'(1));
  assign status_o.quot_nz    = (work_q != '0);
  assign status_o.stack_more = (sp_q != CW'(1));

  itds_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (sp_q[AW-1:0]),
    .wr_data_i (rem_q),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      strobe_q <= 1'b0;
      dcnt_q   <= '0;
      neg_q    <= 1'b0;
      sp_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        radix_q <= clamp_radix(cfg_data_i);
      end
      strobe_q <= strobe_d;
      dcnt_q   <= dcnt_d;
      neg_q    <= neg_d;
      sp_q     <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_o        = out_q;
  assign out_strobe_o = strobe_q;

endmodule

/* rtl/core/integer_to_digit_string_core.sv */
// top level of the integer to digit string converter
// depends on itds_pkg, itds_seq, itds_dp
//
// Converts one number per start into its ASCII digit string in the configured radix,
// most significant digit first, one character per out_strobe_o pulse, with '-' first
// for a negative signed value and last set on the final character. Characters cannot
// be held off: out_strobe_o marks each for exactly one cycle. The work is run by a
// small microcode program over a shared divider that resolves 8 quotient bits a
// cycle, in DIV_STEPS = ceil(VALUE_WIDTH / 8) divider steps per digit; each digit
// is then pushed on a stack, and once all are found the '-' sign, if any, is sent
// and the digits are popped off in turn. Busy stays high while an item is worked on.
// Radix writes are taken at any time but must only be made while idle;
// values below 2 act as 2 and above 36 as 36.
module integer_to_digit_string_core
  import itds_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output out_item_t  out_o,
  output logic       out_strobe_o
);

  uword_t  ctrl;
  status_t status;

  itds_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  itds_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .in_i         (in_i),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_o        (out_o),
    .out_strobe_o (out_strobe_o)
  );

endmodule

/* rtl/core/itds_checker.sv */
// port level checks of the digit string converter, bound to the top level
// depends on itds_pkg
module itds_checker
  import itds_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input out_item_t out_o,
  input logic      out_strobe_o
);

  // a taken item starts work at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after item taken");

  // no character in the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !out_strobe_o)
    else $error("character right after item taken");

  // characters only come from work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy))
    else $error("character while idle");

  // the final character stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && out_o.last) |=> !out_strobe_o)
    else $error("character directly after last");

endmodule

bind integer_to_digit_string_core itds_checker u_itds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_o        (out_o),
  .out_strobe_o (out_strobe_o)
);
